// ===== hdl/lpis_pkg.sv =====
package lpis_pkg;

    localparam int DATA_W     = 8;
    localparam int OUT_W      = 64;
    localparam int FIELD_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int POS_W      = 5;
    localparam int CHARS      = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [DATA_W-1:0]    char_t;

    localparam cfg_index_t CFG_CHARS_LOW  = 2'd0;
    localparam cfg_index_t CFG_CHARS_HIGH = 2'd1;
    localparam cfg_index_t CFG_LENGTH     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_CHARS_LOW  = 64'h0000_0000_0020_2F2F;
    localparam logic [CFG_DATA_W-1:0] RESET_CHARS_HIGH = 64'h0;
    localparam pos_t                  RESET_LENGTH     = 5'd3;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_LOW_A = 8'h61;
    localparam char_t CH_LOW_Z = 8'h7A;
    localparam char_t CASE_BIT = 8'h20;

    function automatic logic is_eol(input char_t c);
        return (c == CH_LF) || (c == CH_NUL);
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic char_t to_upper(input char_t c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? (c - CASE_BIT) : c;
    endfunction

endpackage

// ===== hdl/line_prefix_index_scanner_top.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------------
// s_       | in        | s_tvalid/s_tready  | s_tdata: data_byte[7:0]; s_tlast: end_of_file
// m_       | out       | m_tvalid/m_tready  | m_tdata: line_offset[31:0], match_index[63:32]
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// One byte is taken per cycle unless a stalled result holds input off. A byte sits in the input
// register, and the prefix compare and state update between that register and the result register
// set the result register, which drives m_tvalid after the s_ transfer.
// Reset (aresetn low, synchronous) restores the reset prefix and clears the scan state.
// While a result waits on m_tready, one more byte is held in the input register; then
// s_tready follows m_tready. cfg_ready is always high.
module line_prefix_index_scanner_top #(
    parameter int PREFIX_MAX  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lpis_pkg::DATA_W-1:0]         s_tdata,   // data_byte
    input  logic                                s_tlast,   // end_of_file
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpis_pkg::OUT_W-1:0]          m_tdata,   // line_offset, match_index
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  lpis_pkg::cfg_index_t                cfg_index,
    input  logic [lpis_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CLIP = (PREFIX_MAX < lpis_pkg::CHARS) ? PREFIX_MAX : lpis_pkg::CHARS;
    localparam lpis_pkg::pos_t CLIP_LEN = lpis_pkg::POS_W'(CLIP);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [lpis_pkg::FIELD_W-1:0] MATCH_MAX = '1;

    // Configuration registers
    logic [lpis_pkg::CFG_DATA_W-1:0] chars_low_reg, chars_high_reg;
    lpis_pkg::pos_t                  length_reg;

    // Input register
    logic                    in_vld_reg;
    lpis_pkg::char_t         in_data_reg;
    logic                    in_last_reg;

    // Scan state
    logic                    at_start_reg, at_start_next;
    logic                    cand_reg, cand_next;
    lpis_pkg::pos_t          pos_reg, pos_next;
    logic                    blank_reg, blank_next;
    logic [OFFSET_BITS-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [OFFSET_BITS-1:0]  lso_reg, lso_next;
    logic [lpis_pkg::FIELD_W-1:0] match_cnt_reg, match_cnt_next;

    // Result register
    logic                    out_vld_reg;
    logic [lpis_pkg::FIELD_W-1:0] out_offset_reg, out_index_reg;

    logic                    advance;
    logic                    step;
    logic                    hit;
    lpis_pkg::pos_t          eff_len;
    logic [2*lpis_pkg::CFG_DATA_W-1:0] all_chars;

    assign all_chars = {chars_high_reg, chars_low_reg};
    assign advance   = !out_vld_reg || m_tready;
    assign step      = in_vld_reg && advance;
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {out_index_reg, out_offset_reg};

    // A line end among the prefix characters cuts the prefix at that point.
    always_comb begin
        lpis_pkg::pos_t n;
        n = (length_reg > CLIP_LEN) ? CLIP_LEN : length_reg;
        eff_len = n;
        for (int k = lpis_pkg::CHARS - 1; k >= 0; k--) begin
            if ((lpis_pkg::POS_W'(k) < n) && lpis_pkg::is_eol(all_chars[8*k +: 8])) begin
                eff_len = lpis_pkg::POS_W'(k);
            end
        end
    end

    always_comb begin
        logic            compare;
        lpis_pkg::char_t c;
        lpis_pkg::char_t p;
        c       = in_data_reg;
        compare = 1'b1;
        hit     = 1'b0;
        lso_next   = lso_reg;
        cand_next  = cand_reg;
        pos_next   = pos_reg;
        blank_next = blank_reg;
        p          = all_chars[8*pos_reg[3:0] +: 8];

        if (at_start_reg) begin
            lso_next   = byte_cnt_reg;
            cand_next  = 1'b1;
            pos_next   = '0;
            blank_next = 1'b0;
            if (eff_len == '0) begin
                hit       = 1'b1;
                cand_next = 1'b0;
            end
        end

        if (cand_next && blank_next) begin
            if (lpis_pkg::is_blank(c)) begin
                compare = 1'b0;
            end else if (lpis_pkg::is_eol(c)) begin
                cand_next = 1'b0;
                compare   = 1'b0;
            end else begin
                blank_next = 1'b0;
                pos_next   = pos_next + 5'd1;
                if (pos_next >= eff_len) begin
                    hit       = 1'b1;
                    cand_next = 1'b0;
                    compare   = 1'b0;
                end
            end
        end

        // Positions of 16 and above always meet the length check first.
        if (cand_next && compare) begin
            p = all_chars[8*pos_next[3:0] +: 8];
            if (lpis_pkg::is_eol(c)) begin
                cand_next = 1'b0;
            end else if (pos_next >= eff_len) begin
                hit       = 1'b1;
                cand_next = 1'b0;
            end else if (lpis_pkg::is_blank(p)) begin
                if (lpis_pkg::is_blank(c)) begin
                    blank_next = 1'b1;
                end else begin
                    cand_next = 1'b0;
                end
            end else if (lpis_pkg::to_upper(c) == lpis_pkg::to_upper(p)) begin
                pos_next = pos_next + 5'd1;
                if (pos_next >= eff_len) begin
                    hit       = 1'b1;
                    cand_next = 1'b0;
                end
            end else begin
                cand_next = 1'b0;
            end
        end

        match_cnt_next = match_cnt_reg;
        if (hit && (match_cnt_reg != MATCH_MAX)) begin
            match_cnt_next = match_cnt_reg + 32'd1;
        end

        if (lpis_pkg::is_eol(c)) begin
            at_start_next = 1'b1;
            cand_next     = 1'b0;
            blank_next    = 1'b0;
        end else begin
            at_start_next = 1'b0;
        end

        byte_cnt_next = (byte_cnt_reg != OFFSET_MAX) ? byte_cnt_reg + 1'b1 : byte_cnt_reg;

        if (in_last_reg) begin
            at_start_next  = 1'b1;
            cand_next      = 1'b0;
            pos_next       = '0;
            blank_next     = 1'b0;
            byte_cnt_next  = '0;
            lso_next       = '0;
            match_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg  <= lpis_pkg::RESET_CHARS_LOW;
            chars_high_reg <= lpis_pkg::RESET_CHARS_HIGH;
            length_reg     <= lpis_pkg::RESET_LENGTH;
        end else if (cfg_valid) begin
            case (cfg_index)
                lpis_pkg::CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                lpis_pkg::CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                lpis_pkg::CFG_LENGTH:     length_reg     <= cfg_data[lpis_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg  <= 1'b1;
            cand_reg      <= 1'b0;
            pos_reg       <= '0;
            blank_reg     <= 1'b0;
            byte_cnt_reg  <= '0;
            lso_reg       <= '0;
            match_cnt_reg <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (step) begin
                at_start_reg  <= at_start_next;
                cand_reg      <= cand_next;
                pos_reg       <= pos_next;
                blank_reg     <= blank_next;
                byte_cnt_reg  <= byte_cnt_next;
                lso_reg       <= lso_next;
                match_cnt_reg <= match_cnt_next;
            end
            if (advance) begin
                out_vld_reg <= step && hit;
            end
        end
    end

    // The line start is taken before an end of file clears the scan state.
    always_ff @(posedge aclk) begin
        if (step && hit) begin
            out_offset_reg <= lpis_pkg::FIELD_W'(at_start_reg ? byte_cnt_reg : lso_reg);
            out_index_reg  <= match_cnt_reg;
        end
    end

endmodule

// ===== hdl/lpis_checker.sv =====
module lpis_checker #(
    parameter int OFFSET_BITS = 32
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lpis_pkg::OUT_W-1:0]      m_tdata
);

    localparam logic [lpis_pkg::FIELD_W-1:0] OFFSET_MAX =
        lpis_pkg::FIELD_W'((64'd1 << OFFSET_BITS) - 64'd1);

    // A stalled result keeps its payload until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With a result stalled, one more byte fills the input register and input stops.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready || m_tready)
        else $error("input taken past a full pipeline");

    // Saturated offsets never exceed the counter width.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[lpis_pkg::FIELD_W-1:0] <= OFFSET_MAX)
        else $error("line offset beyond counter range");

endmodule

bind line_prefix_index_scanner_top lpis_checker #(.OFFSET_BITS(OFFSET_BITS)) u_lpis_checker (.*);
